// ----- rtl/core/fcwi_pkg.sv -----
// Shared types and constants for the FORM chunk window indexer.
package fcwi_pkg;

    localparam int MAX_CHUNKS_DEFAULT   = 64;
    localparam int OFFSET_WIDTH_DEFAULT = 32;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] WINDOW_LIMIT_RESET = 32'd4194304;

    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_O = 8'h4F;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_M = 8'h4D;

    localparam int HDR_LEN = 8;

    typedef enum logic [2:0] {
        KIND_CHUNK     = 3'd0,
        KIND_WINDOW    = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_BAD_MAGIC = 3'd3,
        KIND_SHORT     = 3'd4
    } kind_t;

    // Record mask bit positions, in emission order
    localparam int REC_WIN_CLOSE = 0;
    localparam int REC_CHUNK     = 1;
    localparam int REC_FINAL_WIN = 2;
    localparam int REC_TERMINAL  = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  tag;
        logic [31:0]  start_offset;
        logic [32:0]  length;
        logic [5:0]   item_index;
        logic [5:0]   related_index;
        logic [6:0]   count;
        logic [6:0]   window_total;
        logic         last;
    } out_item_t;

    // Everything one input byte produces, expanded into records by the back end
    typedef struct packed {
        logic [3:0]   rec_mask;
        kind_t        term_kind;
        logic [31:0]  a_offset;
        logic [32:0]  a_len;
        logic [5:0]   a_index;
        logic [5:0]   a_first;
        logic [6:0]   a_count;
        logic [31:0]  c_tag;
        logic [31:0]  c_offset;
        logic [31:0]  c_size;
        logic [5:0]   c_index;
        logic [5:0]   c_window;
        logic [31:0]  f_offset;
        logic [32:0]  f_len;
        logic [5:0]   f_index;
        logic [5:0]   f_first;
        logic [6:0]   f_count;
        logic [6:0]   t_chunks;
        logic [6:0]   t_windows;
    } event_t;

endpackage

// ----- rtl/core/fcwi_front.sv -----
// Front end: byte parser, chunk walker and window packer; emits an event per chunk or file end.
module fcwi_front #(
    parameter int MAX_CHUNKS   = fcwi_pkg::MAX_CHUNKS_DEFAULT,
    parameter int OFFSET_WIDTH = fcwi_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  fcwi_pkg::in_item_t byte_item,
    input  logic               cfg_valid,
    input  logic [31:0]        cfg_data,
    input  logic               ev_full,
    output logic               ev_push,
    output fcwi_pkg::event_t   ev
);

    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int OW = OFFSET_WIDTH;

    typedef enum logic [4:0] {
        PH_FILE_HDR  = 5'b00001,
        PH_CHUNK_HDR = 5'b00010,
        PH_SKIP      = 5'b00100,
        PH_IGNORE    = 5'b01000,
        PH_BAD_MAGIC = 5'b10000
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [2:0]     hc_reg, hc_next;
    logic [55:0]    hs_reg, hs_next;
    logic [OW-1:0]  pos_reg, pos_next;
    logic [31:0]    skip_reg, skip_next;
    logic [CW-1:0]  cc_reg, cc_next;
    logic [CW-1:0]  wc_reg, wc_next;
    logic [32:0]    wb_reg, wb_next;
    logic [CW-1:0]  wfc_reg, wfc_next;
    logic [OW-1:0]  wfo_reg, wfo_next;
    logic [OW-1:0]  cs_reg, cs_next;
    logic [31:0]    limit_reg;

    logic           take;
    logic           eof;
    logic [7:0]     b;
    logic           chunk_fire;
    logic           close_a;
    logic           fin;
    logic [31:0]    size;
    logic [32:0]    total;
    logic [33:0]    sum;
    logic [OW-1:0]  cs_eff;
    logic [2:0]     hc_after;
    logic [31:0]    skip_after;
    logic [CW-1:0]  cc_after, wc_after, wfc_after;
    logic [32:0]    wb_after;
    logic [OW-1:0]  wfo_after;
    phase_t         phase_after;
    fcwi_pkg::kind_t term_kind;

    assign byte_ready = !ev_full;
    assign take       = byte_valid && byte_ready;
    assign eof        = byte_item.end_of_file;
    assign b          = byte_item.data_byte;

    assign size  = {b, hs_reg[55:32]};
    assign total = 33'(size) + 33'(fcwi_pkg::HDR_LEN);
    assign sum   = 34'(wb_reg) + 34'(total);

    always_comb
    begin
        phase_after = phase_reg;
        hc_after    = hc_reg;
        hs_next     = hs_reg;
        skip_after  = skip_reg;
        cs_eff      = cs_reg;
        chunk_fire  = 1'b0;
        close_a     = 1'b0;
        cc_after    = cc_reg;
        wc_after    = wc_reg;
        wb_after    = wb_reg;
        wfc_after   = wfc_reg;
        wfo_after   = wfo_reg;

        unique case (phase_reg)
            PH_FILE_HDR:
            begin
                for (int i = 0; i < 7; i++)
                begin
                    if (hc_reg == 3'(i))
                        hs_next[i*8 +: 8] = b;
                end
                if (hc_reg == 3'd7)
                begin
                    hc_after = 3'd0;
                    if (hs_reg[31:0] == {fcwi_pkg::CHAR_M, fcwi_pkg::CHAR_R,
                                         fcwi_pkg::CHAR_O, fcwi_pkg::CHAR_F})
                        phase_after = PH_CHUNK_HDR;
                    else
                        phase_after = PH_BAD_MAGIC;
                end
                else
                begin
                    hc_after = hc_reg + 3'd1;
                end
            end
            PH_CHUNK_HDR:
            begin
                if (hc_reg == 3'd0)
                    cs_eff = pos_reg;
                for (int i = 0; i < 7; i++)
                begin
                    if (hc_reg == 3'(i))
                        hs_next[i*8 +: 8] = b;
                end
                if (hc_reg == 3'd7)
                begin
                    hc_after   = 3'd0;
                    chunk_fire = 1'b1;
                    // a chunk that overflows a nonempty window closes it first
                    close_a    = (wb_reg != 33'd0) && (sum > 34'(limit_reg));
                    cc_after   = cc_reg + CW'(1);
                    if (close_a)
                    begin
                        wc_after  = wc_reg + CW'(1);
                        wfc_after = cc_reg;
                        wfo_after = cs_eff;
                        wb_after  = total;
                    end
                    else
                    begin
                        wb_after  = sum[32:0];
                    end
                    skip_after = size;
                    if (cc_after == CW'(MAX_CHUNKS))
                        phase_after = PH_IGNORE;
                    else if (size != 32'd0)
                        phase_after = PH_SKIP;
                    else
                        phase_after = PH_CHUNK_HDR;
                end
                else
                begin
                    hc_after = hc_reg + 3'd1;
                end
            end
            PH_SKIP:
            begin
                skip_after = skip_reg - 32'd1;
                if (skip_reg == 32'd1)
                    phase_after = PH_CHUNK_HDR;
            end
            PH_IGNORE, PH_BAD_MAGIC:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        fin       = 1'b0;
        term_kind = fcwi_pkg::KIND_DONE;
        if (phase_after == PH_FILE_HDR)
            term_kind = fcwi_pkg::KIND_SHORT;
        else if (phase_after == PH_BAD_MAGIC)
            term_kind = fcwi_pkg::KIND_BAD_MAGIC;
        else
            fin = eof && (cc_after != CW'(0)) && (wb_after != 33'd0);
    end

    always_comb
    begin
        ev                 = '0;
        ev.rec_mask        = '0;
        ev.rec_mask[fcwi_pkg::REC_WIN_CLOSE] = close_a;
        ev.rec_mask[fcwi_pkg::REC_CHUNK]     = chunk_fire;
        ev.rec_mask[fcwi_pkg::REC_FINAL_WIN] = fin;
        ev.rec_mask[fcwi_pkg::REC_TERMINAL]  = eof;
        ev.term_kind       = term_kind;
        ev.a_offset        = 32'(wfo_reg);
        ev.a_len           = wb_reg;
        ev.a_index         = 6'(wc_reg);
        ev.a_first         = 6'(wfc_reg);
        ev.a_count         = 7'(cc_reg - wfc_reg);
        ev.c_tag           = hs_reg[31:0];
        ev.c_offset        = 32'(cs_eff);
        ev.c_size          = size;
        ev.c_index         = 6'(cc_reg);
        ev.c_window        = 6'(wc_after);
        ev.f_offset        = 32'(wfo_after);
        ev.f_len           = wb_after;
        ev.f_index         = 6'(wc_after);
        ev.f_first         = 6'(wfc_after);
        ev.f_count         = 7'(cc_after - wfc_after);
        ev.t_chunks        = 7'(cc_after);
        ev.t_windows       = 7'(wc_after + CW'(fin));
    end

    assign ev_push = take && (chunk_fire || eof);

    always_comb
    begin
        phase_next = phase_after;
        hc_next    = hc_after;
        skip_next  = skip_after;
        pos_next   = pos_reg + OW'(1);
        cc_next    = cc_after;
        wc_next    = wc_after;
        wb_next    = wb_after;
        wfc_next   = wfc_after;
        wfo_next   = wfo_after;
        cs_next    = cs_eff;
        // end of file returns every counter to its start value
        if (eof)
        begin
            phase_next = PH_FILE_HDR;
            hc_next    = 3'd0;
            pos_next   = '0;
            skip_next  = '0;
            cc_next    = '0;
            wc_next    = '0;
            wb_next    = '0;
            wfc_next   = '0;
            wfo_next   = OW'(fcwi_pkg::HDR_LEN);
            cs_next    = OW'(fcwi_pkg::HDR_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FILE_HDR;
            hc_reg    <= '0;
            pos_reg   <= '0;
            skip_reg  <= '0;
            cc_reg    <= '0;
            wc_reg    <= '0;
            wb_reg    <= '0;
            wfc_reg   <= '0;
            wfo_reg   <= OW'(fcwi_pkg::HDR_LEN);
            cs_reg    <= OW'(fcwi_pkg::HDR_LEN);
            limit_reg <= fcwi_pkg::WINDOW_LIMIT_RESET;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                hc_reg    <= hc_next;
                pos_reg   <= pos_next;
                skip_reg  <= skip_next;
                cc_reg    <= cc_next;
                wc_reg    <= wc_next;
                wb_reg    <= wb_next;
                wfc_reg   <= wfc_next;
                wfo_reg   <= wfo_next;
                cs_reg    <= cs_next;
            end
            if (cfg_valid)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            hs_reg <= hs_next;
    end

endmodule

// ----- rtl/core/fcwi_queue.sv -----
// Event queue between the parser and the record expander.
module fcwi_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fcwi_pkg::event_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output fcwi_pkg::event_t head
);

    localparam int DEPTH = fcwi_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    fcwi_pkg::event_t entry_reg [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [NW-1:0]    num_reg;
    logic             do_push, do_pop;

    assign full    = (num_reg == NW'(DEPTH));
    assign empty   = (num_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            num_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            if (do_push && !do_pop)
                num_reg <= num_reg + NW'(1);
            else if (do_pop && !do_push)
                num_reg <= num_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_data;
    end

endmodule

// ----- rtl/core/fcwi_back.sv -----
// Back end: expands each event into its records, one beat per cycle while rec_ready allows.
module fcwi_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  fcwi_pkg::event_t    q_head,
    output logic                q_pop,
    output logic                rec_valid,
    input  logic                rec_ready,
    output fcwi_pkg::out_item_t rec_item
);

    fcwi_pkg::event_t    cur_reg;
    logic [3:0]          pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    fcwi_pkg::out_item_t out_reg;
    fcwi_pkg::out_item_t rec;
    logic [3:0]          rest;
    logic                adv;
    logic                load;

    assign adv  = (pend_reg != 4'd0) && (!out_valid_reg || rec_ready);
    assign rest = pend_reg & (pend_reg - 4'd1);
    assign load = ((pend_reg == 4'd0) || (adv && rest == 4'd0)) && !q_empty;
    assign q_pop = load;

    always_comb
    begin
        rec       = '0;
        rec.kind  = fcwi_pkg::KIND_CHUNK;
        rec.last  = (rest == 4'd0);
        priority if (pend_reg[fcwi_pkg::REC_WIN_CLOSE])
        begin
            rec.kind          = fcwi_pkg::KIND_WINDOW;
            rec.start_offset  = cur_reg.a_offset;
            rec.length        = cur_reg.a_len;
            rec.item_index    = cur_reg.a_index;
            rec.related_index = cur_reg.a_first;
            rec.count         = cur_reg.a_count;
        end
        else if (pend_reg[fcwi_pkg::REC_CHUNK])
        begin
            rec.kind          = fcwi_pkg::KIND_CHUNK;
            rec.tag           = cur_reg.c_tag;
            rec.start_offset  = cur_reg.c_offset;
            rec.length        = {1'b0, cur_reg.c_size};
            rec.item_index    = cur_reg.c_index;
            rec.related_index = cur_reg.c_window;
        end
        else if (pend_reg[fcwi_pkg::REC_FINAL_WIN])
        begin
            rec.kind          = fcwi_pkg::KIND_WINDOW;
            rec.start_offset  = cur_reg.f_offset;
            rec.length        = cur_reg.f_len;
            rec.item_index    = cur_reg.f_index;
            rec.related_index = cur_reg.f_first;
            rec.count         = cur_reg.f_count;
        end
        else
        begin
            rec.kind = cur_reg.term_kind;
            if (cur_reg.term_kind == fcwi_pkg::KIND_DONE)
            begin
                rec.count        = cur_reg.t_chunks;
                rec.window_total = cur_reg.t_windows;
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (load)
            pend_next = q_head.rec_mask;
        else if (adv)
            pend_next = rest;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (rec_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_head;
        if (adv)
            out_reg <= rec;
    end

    assign rec_valid = out_valid_reg;
    assign rec_item  = out_reg;

endmodule

// ----- rtl/core/form_chunk_window_indexer.sv -----
// Top level of the FORM chunk window indexer.
//
//  channel  direction  handshake              beat payload
//  byte     in         byte_valid/byte_ready  in_item_t: data_byte, end_of_file
//  rec      out        rec_valid/rec_ready    out_item_t: one chunk/window/summary record
//  cfg      in         cfg_valid/cfg_ready    window_limit, 32 bits
//
// One byte beat per cycle; header bytes complete in the cycle they arrive.
// A byte yields zero to four records, drained one per cycle while rec_ready is high
// from a four-event queue into a registered output stage; records follow only the
// eighth byte of a chunk header or the end-of-file byte.
// Reset is asynchronous, active low; no clearing pass is needed.
// byte_ready drops only while the event queue is full.
module form_chunk_window_indexer #(
    parameter int MAX_CHUNKS   = fcwi_pkg::MAX_CHUNKS_DEFAULT,
    parameter int OFFSET_WIDTH = fcwi_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  fcwi_pkg::in_item_t  byte_item,
    output logic                rec_valid,
    input  logic                rec_ready,
    output fcwi_pkg::out_item_t rec_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    fcwi_pkg::event_t ev;
    fcwi_pkg::event_t q_head;
    logic             ev_push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    fcwi_front #(
        .MAX_CHUNKS   (MAX_CHUNKS),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .ev_full    (q_full),
        .ev_push    (ev_push),
        .ev         (ev)
    );

    fcwi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_push),
        .push_data (ev),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    fcwi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_item  (rec_item)
    );

endmodule

// ----- tb/fcwi_index_checker.sv -----
// Watches the byte, record and limit channels, predicts every record and compares.
`timescale 1ns / 100ps

module fcwi_index_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_ready,
    input  fcwi_pkg::in_item_t  byte_item,
    input  logic                rec_valid,
    input  logic                rec_ready,
    input  fcwi_pkg::out_item_t rec_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    output int                  error_count,
    output int                  records_due
);

    typedef enum logic [4:0] {
        SCAN_FILE_HDR  = 5'b00001,
        SCAN_CHUNK_HDR = 5'b00010,
        SCAN_SKIP      = 5'b00100,
        SCAN_IGNORE    = 5'b01000,
        SCAN_BAD_MAGIC = 5'b10000
    } scan_phase_t;

    logic [31:0]  limit_bytes;
    scan_phase_t  phase;
    int           hdr_cnt;
    logic [63:0]  hdr_shift;
    logic [31:0]  byte_pos;
    logic [32:0]  skip_left;
    logic [6:0]   chunk_cnt;
    logic [6:0]   win_cnt;
    logic [32:0]  win_bytes;
    logic [5:0]   win_first_chunk;
    logic [31:0]  win_first_off;
    logic [31:0]  chunk_start;

    fcwi_pkg::out_item_t step_records[$];
    fcwi_pkg::out_item_t pending_records[$];
    int                  records_checked;

    function automatic void clear_scan();
        phase           = SCAN_FILE_HDR;
        hdr_cnt         = 0;
        hdr_shift       = '0;
        byte_pos        = '0;
        skip_left       = '0;
        chunk_cnt       = '0;
        win_cnt         = '0;
        win_bytes       = '0;
        win_first_chunk = '0;
        win_first_off   = 32'd8;
        chunk_start     = 32'd8;
    endfunction

    function automatic void add_record(fcwi_pkg::kind_t k, logic [31:0] tag, logic [31:0] off,
                                       logic [32:0] len, logic [5:0] idx, logic [5:0] rel,
                                       logic [6:0] cnt, logic [6:0] wtot);
        fcwi_pkg::out_item_t r;
        r               = '0;
        r.kind          = k;
        r.tag           = tag;
        r.start_offset  = off;
        r.length        = len;
        r.item_index    = idx;
        r.related_index = rel;
        r.count         = cnt;
        r.window_total  = wtot;
        step_records.push_back(r);
    endfunction

    function automatic void close_window();
        add_record(fcwi_pkg::KIND_WINDOW, '0, win_first_off, win_bytes, win_cnt[5:0],
                   win_first_chunk, chunk_cnt - {1'b0, win_first_chunk}, '0);
        win_cnt   = win_cnt + 7'd1;
        win_bytes = '0;
    endfunction

    function automatic void take_chunk();
        logic [31:0] tag;
        logic [31:0] pay_size;
        logic [63:0] total;
        tag      = hdr_shift[31:0];
        pay_size = hdr_shift[63:32];
        total    = {32'b0, pay_size} + 64'd8;
        // sums can pass 33 bits here, so compare at 64
        if (win_bytes != 0 && {31'b0, win_bytes} + total > {32'b0, limit_bytes}) begin
            close_window();
            win_first_chunk = chunk_cnt[5:0];
            win_first_off   = chunk_start;
        end
        add_record(fcwi_pkg::KIND_CHUNK, tag, chunk_start, {1'b0, pay_size}, chunk_cnt[5:0],
                   win_cnt[5:0], '0, '0);
        win_bytes = win_bytes + total[32:0];
        chunk_cnt = chunk_cnt + 7'd1;
        skip_left = {1'b0, pay_size};
        if (chunk_cnt >= fcwi_pkg::MAX_CHUNKS_DEFAULT)
            phase = SCAN_IGNORE;
        else
            phase = (pay_size != 0) ? SCAN_SKIP : SCAN_CHUNK_HDR;
    endfunction

    function automatic void index_byte(logic [7:0] b, logic eof);
        logic ok;
        step_records.delete();
        unique case (phase)
            SCAN_FILE_HDR:
            begin
                hdr_shift[8*hdr_cnt +: 8] = b;
                hdr_cnt++;
                if (hdr_cnt == fcwi_pkg::HDR_LEN) begin
                    ok = hdr_shift[7:0] == fcwi_pkg::CHAR_F &&
                         hdr_shift[15:8] == fcwi_pkg::CHAR_O &&
                         hdr_shift[23:16] == fcwi_pkg::CHAR_R &&
                         hdr_shift[31:24] == fcwi_pkg::CHAR_M;
                    hdr_cnt   = 0;
                    hdr_shift = '0;
                    phase     = ok ? SCAN_CHUNK_HDR : SCAN_BAD_MAGIC;
                end
            end
            SCAN_CHUNK_HDR:
            begin
                if (hdr_cnt == 0)
                    chunk_start = byte_pos;
                hdr_shift[8*hdr_cnt +: 8] = b;
                hdr_cnt++;
                if (hdr_cnt == fcwi_pkg::HDR_LEN) begin
                    take_chunk();
                    hdr_cnt   = 0;
                    hdr_shift = '0;
                end
            end
            SCAN_SKIP:
            begin
                if (skip_left != 0)
                    skip_left = skip_left - 33'd1;
                if (skip_left == 0)
                    phase = SCAN_CHUNK_HDR;
            end
            default:
            begin
            end
        endcase
        byte_pos = byte_pos + 32'd1;

        if (eof) begin
            if (phase == SCAN_FILE_HDR)
                add_record(fcwi_pkg::KIND_SHORT, '0, '0, '0, '0, '0, '0, '0);
            else if (phase == SCAN_BAD_MAGIC)
                add_record(fcwi_pkg::KIND_BAD_MAGIC, '0, '0, '0, '0, '0, '0, '0);
            else begin
                if (chunk_cnt != 0 && win_bytes != 0)
                    close_window();
                add_record(fcwi_pkg::KIND_DONE, '0, '0, '0, '0, '0, chunk_cnt, win_cnt);
            end
            clear_scan();
        end

        // flag the final record of this byte
        foreach (step_records[i]) begin
            fcwi_pkg::out_item_t r;
            r      = step_records[i];
            r.last = (i == step_records.size() - 1);
            pending_records.push_back(r);
        end
    endfunction

    function automatic void compare_field(string name, logic [32:0] got, logic [32:0] want);
        if (got !== want) begin
            $display("%0t ns: record %0d field %s expected 0x%0h got 0x%0h",
                     $time, records_checked, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_record(fcwi_pkg::out_item_t got);
        fcwi_pkg::out_item_t want;
        if (pending_records.size() == 0) begin
            $display("%0t ns: record %0d expected none got kind %0d tag 0x%0h offset 0x%0h",
                     $time, records_checked, got.kind, got.tag, got.start_offset);
            error_count++;
        end
        else begin
            want = pending_records.pop_front();
            compare_field("kind",          33'(got.kind),          33'(want.kind));
            compare_field("tag",           33'(got.tag),           33'(want.tag));
            compare_field("start_offset",  33'(got.start_offset),  33'(want.start_offset));
            compare_field("length",        got.length,             want.length);
            compare_field("item_index",    33'(got.item_index),    33'(want.item_index));
            compare_field("related_index", 33'(got.related_index), 33'(want.related_index));
            compare_field("count",         33'(got.count),         33'(want.count));
            compare_field("window_total",  33'(got.window_total),  33'(want.window_total));
            compare_field("last",          33'(got.last),          33'(want.last));
        end
        records_checked++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_bytes = fcwi_pkg::WINDOW_LIMIT_RESET;
            clear_scan();
            pending_records.delete();
            error_count     = 0;
            records_checked = 0;
            records_due     = 0;
        end
        else begin
            if (rec_valid && rec_ready)
                check_record(rec_item);
            if (byte_valid && byte_ready)
                index_byte(byte_item.data_byte, byte_item.end_of_file);
            if (cfg_valid && cfg_ready)
                limit_bytes = cfg_data;
            records_due = pending_records.size();
        end
    end

endmodule

// ----- tb/tb_form_chunk_window_indexer.sv -----
// Stimulus and verdict for the FORM chunk window indexer.
`timescale 1ns / 100ps

module tb_form_chunk_window_indexer;

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_ready;
    fcwi_pkg::in_item_t  byte_item;
    logic                rec_valid;
    logic                rec_ready;
    fcwi_pkg::out_item_t rec_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [31:0]         cfg_data;

    int          error_count;
    int          records_due;
    int          bytes_sent = 0;
    logic [7:0]  file_bytes[$];

    form_chunk_window_indexer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_item   (rec_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    fcwi_index_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec_item    (rec_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .records_due (records_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL form_chunk_window_indexer");
        $finish;
    end

    // Record sink: mostly short stalls, a few long ones, and calm stretches.
    initial
    begin : rec_sink
        int hold;
        int r;
        int cyc;
        hold      = 0;
        cyc       = 0;
        rec_ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (hold > 0) begin
                rec_ready <= 1'b0;
                hold--;
            end
            else begin
                rec_ready <= 1'b1;
                r = $urandom_range(99);
                if ((cyc / 300) % 4 == 1)
                    hold = 0;
                else if (r < 20)
                    hold = $urandom_range(1, 3);
                else if (r < 24)
                    hold = $urandom_range(8, 40);
                else
                    hold = 0;
            end
        end
    end

    function automatic int gap_len(bit steady);
        int r;
        r = $urandom_range(99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void add_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_chunk(logic [31:0] tag, logic [31:0] pay_size, int body);
        add_word(tag);
        add_word(pay_size);
        for (int i = 0; i < body; i++)
            file_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic logic [31:0] pick_tag();
        logic [31:0] t;
        if ($urandom_range(3) == 0)
            return $urandom;
        for (int i = 0; i < 4; i++)
            t[8*i +: 8] = 8'(32'h41 + $urandom_range(25));
        return t;
    endfunction

    function automatic logic [31:0] pick_limit();
        unique case ($urandom_range(5))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return fcwi_pkg::WINDOW_LIMIT_RESET;
            3:       return 32'd24;
            4:       return 32'd40;
            default: return $urandom_range(8, 80);
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b, logic eof);
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: b, end_of_file: eof};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Hold the byte channel until every predicted record has been taken.
    task automatic wait_drain();
        byte_valid <= 1'b0;
        @(negedge clk);
        while (records_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(logic [31:0] v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_file(int drain_at, bit steady);
        int n;
        for (int i = 0; i < file_bytes.size(); i++) begin
            n = gap_len(steady);
            if (i == drain_at)
                wait_drain();
            else if (n > 0) begin
                byte_valid <= 1'b0;
                repeat (n) @(negedge clk);
            end
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
    endtask

    task automatic build_good_file();
        int n;
        int r;
        int cut;
        logic [31:0] pay_size;
        add_word({fcwi_pkg::CHAR_M, fcwi_pkg::CHAR_R, fcwi_pkg::CHAR_O, fcwi_pkg::CHAR_F});
        add_word($urandom);
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 80)
                pay_size = $urandom_range(0, 12);
            else if (r < 90)
                pay_size = $urandom_range(13, 40);
            else
                pay_size = $urandom;
            if (pay_size > 40) begin
                // payload runs past the end of the file
                add_chunk(pick_tag(), pay_size, $urandom_range(0, 6));
                break;
            end
            add_chunk(pick_tag(), pay_size, pay_size);
        end
        // cut inside a header or a payload now and then
        if ($urandom_range(2) == 0) begin
            cut = $urandom_range(9, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endtask

    task automatic build_random_file();
        logic [31:0] magic;
        int r;
        int n;
        file_bytes.delete();
        r = $urandom_range(99);
        if (r < 70)
            build_good_file();
        else if (r < 80) begin
            magic = {fcwi_pkg::CHAR_M, fcwi_pkg::CHAR_R, fcwi_pkg::CHAR_O, fcwi_pkg::CHAR_F};
            n = $urandom_range(0, 3);
            magic[8*n +: 8] = magic[8*n +: 8] ^ 8'($urandom_range(1, 255));
            add_word(magic);
            add_word($urandom);
            repeat ($urandom_range(0, 20)) file_bytes.push_back(8'($urandom_range(255)));
        end
        else if (r < 90) begin
            file_bytes.push_back(fcwi_pkg::CHAR_F);
            repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(255)));
        end
        else begin
            repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        int file_no;
        int drain_at;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_limit(32'd1);

        // short file header
        file_bytes.delete();
        file_bytes.push_back(fcwi_pkg::CHAR_F);
        file_bytes.push_back(8'h00);
        send_file(-1, 1'b1);

        // bad magic ending right on the eighth byte
        file_bytes.delete();
        add_word({8'h6D, fcwi_pkg::CHAR_R, fcwi_pkg::CHAR_O, fcwi_pkg::CHAR_F});
        add_word(32'hFFFF_FFFF);
        send_file(-1, 1'b1);

        // largest chunk size: its window passes 32 bits, file ends on its header
        file_bytes.delete();
        add_word({fcwi_pkg::CHAR_M, fcwi_pkg::CHAR_R, fcwi_pkg::CHAR_O, fcwi_pkg::CHAR_F});
        add_word(32'h0000_0000);
        add_chunk(32'h4154_4144, 32'hFFFF_FFFF, 0);
        send_file(-1, 1'b1);

        write_limit(32'hFFFF_FFFF);

        file_no = 0;
        while (bytes_sent < 130) begin
            if (file_no > 0 && $urandom_range(2) == 0)
                write_limit(pick_limit());
            build_random_file();
            if (file_no == 0 || $urandom_range(3) == 0)
                drain_at = $urandom_range(0, file_bytes.size() - 1);
            else
                drain_at = -1;
            send_file(drain_at, $urandom_range(4) == 0);
            file_no++;
        end

        wait_drain();
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("PASS form_chunk_window_indexer");
        else
            $display("FAIL form_chunk_window_indexer");
        $finish;
    end

endmodule
